// File: rtl/mset_pkg.sv
// ----------------------------------------------------------------------------
// mset_pkg
// shared types, codes and constants of the midi stream event timer
// ----------------------------------------------------------------------------
package mset_pkg;

   // event word decode
   localparam logic [7:0]  EVENT_TYPE_MASK  = 8'hBF;
   localparam logic [7:0]  TYPE_SHORT       = 8'h00;
   localparam logic [7:0]  TYPE_TEMPO       = 8'h01;
   localparam logic [7:0]  TYPE_LONG        = 8'h80;

   localparam int          PARAM_W          = 24;
   localparam int          BYTE_INC_W       = 25;
   localparam logic [BYTE_INC_W-1:0] HEADER_BYTES = 25'h000000C;

   // timing defaults
   localparam logic [23:0] DEFAULT_TEMPO    = 24'd500000;
   localparam logic [15:0] DEFAULT_DIVISION = 16'h0018;
   localparam int          FRAME_W          = 20;
   localparam logic [FRAME_W-1:0] FRAME_US  = 20'd1000000;

   // wait divider: 56-bit dividend, two quotient bits per cycle
   localparam int          DIVIDEND_W       = 56;
   localparam int          DIV_STEPS        = DIVIDEND_W / 2;
   localparam int          STEP_W           = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(DIV_STEPS - 1);

   localparam int          QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_LONG  = 2'd2,
      KIND_TEMPO = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      WAIT_ZERO   = 2'd0,
      WAIT_METRIC = 2'd1,
      WAIT_SMPTE  = 2'd2
   } wait_sel_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_MUL    = 2'd1,
      BK_DIV    = 2'd2,
      BK_FINISH = 2'd3
   } back_state_type;

   // one classified event as it sits in the queue
   typedef struct packed {
      logic                  clear;
      wait_sel_type          wait_sel;
      kind_type              kind;
      logic                  callback;
      logic [31:0]           delta;
      logic [PARAM_W-1:0]    param;
      logic [BYTE_INC_W-1:0] byte_inc;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

endpackage

// File: rtl/mset_channels.sv
// ----------------------------------------------------------------------------
// mset channels
// valid/ready channels of the event timer: request, response, csr write
// ----------------------------------------------------------------------------
interface mset_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] delta_ticks;
   logic [31:0] event_word;

   modport source (output valid, mode, delta_ticks, event_word, input ready);
   modport sink   (input valid, mode, delta_ticks, event_word, output ready);
endinterface

interface mset_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  message_kind;
   logic [7:0]  status_byte;
   logic [7:0]  first_data;
   logic [7:0]  second_data;
   logic [23:0] long_length;
   logic [31:0] wait_micros;
   logic        position_callback;
   logic [31:0] total_ticks;
   logic [31:0] total_micros;
   logic [31:0] total_bytes;

   modport source (output valid, message_kind, status_byte, first_data, second_data,
                   long_length, wait_micros, position_callback, total_ticks,
                   total_micros, total_bytes, input ready);
   modport sink   (input valid, message_kind, status_byte, first_data, second_data,
                   long_length, wait_micros, position_callback, total_ticks,
                   total_micros, total_bytes, output ready);
endinterface

interface mset_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] time_division;

   modport source (output valid, time_division, input ready);
   modport sink   (input valid, time_division, output ready);
endinterface

// File: rtl/mset_front.sv
// ----------------------------------------------------------------------------
// mset_front
// accepts request beats and classifies them into queue entries
// ----------------------------------------------------------------------------
module mset_front
   import mset_pkg::*;
(
   mset_req_if.sink   req_chan,
   input  logic [15:0] time_division,
   input  logic        q_full,
   output q_push_type  push
);

   logic [7:0]            ev_type;
   logic [PARAM_W-1:0]    param;
   logic [BYTE_INC_W-1:0] padded_len;
   logic                  smpte;
   logic [6:0]            frame_rate;
   logic [7:0]            frame_ticks;
   entry_type             entry;

   assign ev_type     = req_chan.event_word[31:24] & EVENT_TYPE_MASK;
   assign param       = req_chan.event_word[PARAM_W-1:0];
   assign smpte       = time_division[15];
   assign frame_rate  = time_division[14:8];
   assign frame_ticks = time_division[7:0];
   // long payload rounded up to a word
   assign padded_len  = (BYTE_INC_W'(param) + BYTE_INC_W'(3)) & ~BYTE_INC_W'(3);

   always_comb begin
      entry          = '0;
      entry.clear    = req_chan.mode;
      entry.delta    = req_chan.delta_ticks;
      entry.param    = param;
      entry.kind     = KIND_NONE;
      entry.wait_sel = WAIT_ZERO;
      entry.callback = 1'b0;
      entry.byte_inc = '0;
      if (!req_chan.mode) begin
         entry.callback = req_chan.event_word[30];
         entry.byte_inc = HEADER_BYTES + (req_chan.event_word[31] ? padded_len : '0);
         unique case (ev_type)
            TYPE_SHORT: entry.kind = KIND_SHORT;
            TYPE_LONG:  entry.kind = KIND_LONG;
            TYPE_TEMPO: entry.kind = smpte ? KIND_NONE : KIND_TEMPO;
            default:    entry.kind = KIND_NONE;
         endcase
         if (smpte) begin
            if (frame_rate != '0 && frame_ticks != '0) begin
               entry.wait_sel = WAIT_SMPTE;
            end
         end else if (req_chan.delta_ticks != '0 && time_division != '0) begin
            entry.wait_sel = WAIT_METRIC;
         end
      end
   end

   assign req_chan.ready = !q_full;
   assign push.valid     = req_chan.valid && !q_full;
   assign push.entry     = entry;

endmodule

// File: rtl/mset_queue.sv
// ----------------------------------------------------------------------------
// mset_queue
// short register fifo between front and back
// ----------------------------------------------------------------------------
module mset_queue
   import mset_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  q_push_type push,
   output logic       full,
   output q_head_type head,
   input  logic       pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type         slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/mset_back.sv
// ----------------------------------------------------------------------------
// mset_back
// computes the wait, updates tempo and accumulators, holds the result
// ----------------------------------------------------------------------------
module mset_back
   import mset_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] time_division,
   input  q_head_type  head,
   output logic        pop,
   mset_rsp_if.source  rsp_chan
);

   // one restoring step: remainder stays below the 16-bit divisor
   function automatic logic [16+DIVIDEND_W-1:0] div_step(input logic [15:0] r,
                                                         input logic [DIVIDEND_W-1:0] q,
                                                         input logic [15:0] d);
      logic [16:0] t;
      logic [16:0] diff;
      t    = {r, q[DIVIDEND_W-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         return {diff[15:0], q[DIVIDEND_W-2:0], 1'b1};
      end
      return {t[15:0], q[DIVIDEND_W-2:0], 1'b0};
   endfunction

   back_state_type        state_ff, state_in;
   entry_type             ent_ff, ent_in;
   logic [23:0]           tempo_ff, tempo_in;
   logic [31:0]           ticks_acc_ff, ticks_acc_in;
   logic [31:0]           micros_acc_ff, micros_acc_in;
   logic [31:0]           bytes_acc_ff, bytes_acc_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [15:0]           rem_ff, rem_in;
   logic [15:0]           divisor_ff, divisor_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  pass2_ff, pass2_in;
   logic [31:0]           wait_ff, wait_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [7:0]            status_ff, status_in;
   logic [7:0]            data1_ff, data1_in;
   logic [7:0]            data2_ff, data2_in;
   logic [23:0]           len_ff, len_in;
   logic [31:0]           wait_out_ff, wait_out_in;
   logic                  cb_ff, cb_in;
   logic [31:0]           tot_ticks_ff, tot_ticks_in;
   logic [31:0]           tot_micros_ff, tot_micros_in;
   logic [31:0]           tot_bytes_ff, tot_bytes_in;

   logic                  out_free;
   logic                  load_mul, run_div, out_load;
   logic [15:0]           r1, r2;
   logic [DIVIDEND_W-1:0] q1, q2;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.wait_sel)
                  WAIT_METRIC: state_in = BK_MUL;
                  WAIT_SMPTE:  state_in = BK_DIV;
                  default:     state_in = BK_FINISH;
               endcase
            end
         end
         BK_MUL: state_in = BK_DIV;
         BK_DIV: begin
            if (step_ff == STEP_LAST && !pass2_ff) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = 1'b0;
      load_mul = 1'b0;
      run_div  = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         BK_IDLE:   pop      = head.valid;
         BK_MUL:    load_mul = 1'b1;
         BK_DIV:    run_div  = 1'b1;
         BK_FINISH: out_load = out_free;
         default:   pop      = 1'b0;
      endcase
   end

   assign {r1, q1} = div_step(rem_ff, quot_ff, divisor_ff);
   assign {r2, q2} = div_step(r1, q1, divisor_ff);

   // datapath
   always_comb begin
      ent_in        = ent_ff;
      tempo_in      = tempo_ff;
      ticks_acc_in  = ticks_acc_ff;
      micros_acc_in = micros_acc_ff;
      bytes_acc_in  = bytes_acc_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      step_in       = step_ff;
      pass2_in      = pass2_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      kind_in       = kind_ff;
      status_in     = status_ff;
      data1_in      = data1_ff;
      data2_in      = data2_ff;
      len_in        = len_ff;
      wait_out_in   = wait_out_ff;
      cb_in         = cb_ff;
      tot_ticks_in  = tot_ticks_ff;
      tot_micros_in = tot_micros_ff;
      tot_bytes_in  = tot_bytes_ff;

      if (pop) begin
         ent_in     = head.entry;
         wait_in    = '0;
         pass2_in   = (head.entry.wait_sel == WAIT_SMPTE);
         // smpte first pass: frame microseconds over frame rate
         quot_in    = DIVIDEND_W'(FRAME_US);
         divisor_in = 16'(time_division[14:8]);
         rem_in     = '0;
         step_in    = '0;
      end

      if (load_mul) begin
         quot_in    = DIVIDEND_W'(tempo_ff * ent_ff.delta);
         divisor_in = time_division;
         rem_in     = '0;
         step_in    = '0;
      end

      if (run_div) begin
         rem_in  = r2;
         quot_in = q2;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            step_in = '0;
            rem_in  = '0;
            if (pass2_ff) begin
               // smpte second pass: over ticks per frame
               pass2_in   = 1'b0;
               quot_in    = DIVIDEND_W'(q2[FRAME_W-1:0]);
               divisor_in = 16'(time_division[7:0]);
            end else begin
               wait_in = (|q2[DIVIDEND_W-1:32]) ? '1 : q2[31:0];
            end
         end
      end

      if (out_load) begin
         if (ent_ff.clear) begin
            ticks_acc_in  = '0;
            micros_acc_in = '0;
            bytes_acc_in  = '0;
            tempo_in      = DEFAULT_TEMPO;
         end else begin
            ticks_acc_in  = ticks_acc_ff + ent_ff.delta;
            micros_acc_in = micros_acc_ff + wait_ff;
            bytes_acc_in  = bytes_acc_ff + 32'(ent_ff.byte_inc);
            if (ent_ff.kind == KIND_TEMPO) begin
               tempo_in = ent_ff.param;
            end
         end
         rsp_valid_in  = 1'b1;
         kind_in       = ent_ff.kind;
         status_in     = (ent_ff.kind == KIND_SHORT) ? ent_ff.param[23:16] : '0;
         data1_in      = (ent_ff.kind == KIND_SHORT) ? ent_ff.param[15:8] : '0;
         data2_in      = (ent_ff.kind == KIND_SHORT) ? ent_ff.param[7:0] : '0;
         len_in        = (ent_ff.kind == KIND_LONG) ? ent_ff.param : '0;
         wait_out_in   = wait_ff;
         cb_in         = ent_ff.callback;
         tot_ticks_in  = ticks_acc_in;
         tot_micros_in = micros_acc_in;
         tot_bytes_in  = bytes_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pass2_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tempo_ff      <= DEFAULT_TEMPO;
         ticks_acc_ff  <= '0;
         micros_acc_ff <= '0;
         bytes_acc_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         pass2_ff      <= pass2_in;
         rsp_valid_ff  <= rsp_valid_in;
         tempo_ff      <= tempo_in;
         ticks_acc_ff  <= ticks_acc_in;
         micros_acc_ff <= micros_acc_in;
         bytes_acc_ff  <= bytes_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      step_ff       <= step_in;
      wait_ff       <= wait_in;
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      data1_ff      <= data1_in;
      data2_ff      <= data2_in;
      len_ff        <= len_in;
      wait_out_ff   <= wait_out_in;
      cb_ff         <= cb_in;
      tot_ticks_ff  <= tot_ticks_in;
      tot_micros_ff <= tot_micros_in;
      tot_bytes_ff  <= tot_bytes_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.message_kind      = kind_ff;
   assign rsp_chan.status_byte       = status_ff;
   assign rsp_chan.first_data        = data1_ff;
   assign rsp_chan.second_data       = data2_ff;
   assign rsp_chan.long_length       = len_ff;
   assign rsp_chan.wait_micros       = wait_out_ff;
   assign rsp_chan.position_callback = cb_ff;
   assign rsp_chan.total_ticks       = tot_ticks_ff;
   assign rsp_chan.total_micros      = tot_micros_ff;
   assign rsp_chan.total_bytes       = tot_bytes_ff;

endmodule

// File: rtl/midi_stream_event_timer.sv
// ----------------------------------------------------------------------------
// midi_stream_event_timer
// Times and decodes midi stream events. Each request beat is either a clear
// (accumulators to zero, tempo back to 500000 us per quarter) or an event with
// a delta tick count and an event word; every beat yields one response beat
// with the decoded message, the wait before the event and the running tick,
// microsecond and byte totals. In metrical mode the wait is
// tempo * delta / ticks-per-quarter, saturated to 32 bits; in smpte mode it is
// (1000000 / frame rate) / ticks-per-frame. The wait comes from one shared
// restoring divider that retires two quotient bits a cycle over a 56-bit
// dividend; a metrical item goes through a multiply step and one divide pass,
// a smpte item through two divide passes, and a clear or a zero wait goes
// straight to the result register. Request beats are classified and queued
// up front, so the request side keeps taking beats while the divider runs or
// a result waits, until the queue is full. The user is to write time_division
// over the csr channel only while the block is idle; the block itself does not
// enforce it. time_division resets to 24.
// ----------------------------------------------------------------------------
module midi_stream_event_timer
   import mset_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mset_req_if.sink   req_chan,
   mset_rsp_if.source rsp_chan,
   mset_csr_if.sink   csr_chan
);

   logic [15:0] time_division_ff;
   logic        q_full;
   logic        q_pop;
   q_push_type  q_push;
   q_head_type  q_head;

   // csr write beats are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_division_ff <= DEFAULT_DIVISION;
      end else if (csr_chan.valid) begin
         time_division_ff <= csr_chan.time_division;
      end
   end

   // front: decode type byte, byte increment and wait selection
   mset_front u_front (
      .req_chan      (req_chan),
      .time_division (time_division_ff),
      .q_full        (q_full),
      .push          (q_push)
   );

   // queue between classification and timing
   mset_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   // back: multiply, divide, accumulate, response register
   mset_back u_back (
      .clock         (clock),
      .reset         (reset),
      .time_division (time_division_ff),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_chan      (rsp_chan)
   );

endmodule

// File: rtl/mset_checker.sv
// ----------------------------------------------------------------------------
// mset_checker
// port-level checks of the event timer, bound to the top level
// ----------------------------------------------------------------------------
module mset_checker
   import mset_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [23:0] rsp_long_length,
   input logic [31:0] rsp_total_bytes
);

   // after reset the queue is empty and no result is pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("response pending or request blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_total_bytes))
      else $error("response total changed while stalled");

   // only a long message carries a payload length
   a_len_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_LONG) |-> (rsp_long_length == '0))
      else $error("long length set on a non-long message");

endmodule

bind midi_stream_event_timer mset_checker u_mset_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.message_kind),
   .rsp_long_length (rsp_chan.long_length),
   .rsp_total_bytes (rsp_chan.total_bytes)
);
